// ===== src/pdws_pkg.sv =====
package pdws_pkg;

  // Run layout
  localparam int RUN_BITS  = 40;
  localparam int WORD_BITS = 24;
  localparam int BIT_CNT_W = $clog2(RUN_BITS);

  // Divider sizing
  localparam int DIV_STEPS = 32;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  // Queue depth default
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register reset values
  localparam logic [31:0] IF_OFFSET_RST = 32'd21400000;
  localparam logic [31:0] STEP_RST      = 32'd5000;
  localparam logic [7:0]  MODULUS_RST   = 8'd127;
  localparam logic [15:0] REF_WORD_RST  = 16'h1681;

  // Register indexes
  typedef enum logic [1:0] {
    REG_IF_OFFSET = 2'd0,
    REG_STEP      = 2'd1,
    REG_MODULUS   = 2'd2,
    REG_REF_WORD  = 2'd3
  } reg_index_t;

  // Configuration bundle
  typedef struct packed {
    logic [31:0] if_offset_hz;
    logic [31:0] step_hz;
    logic [7:0]  prescaler_modulus;
    logic [15:0] ref_word;
  } cfg_t;

  // Queued N/A word
  typedef struct packed {
    logic [15:0] n;
    logic [7:0]  a2;
  } na_word_t;

  // Front state machine
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_FIN,
    FR_PUSH
  } front_state_t;

endpackage

// ===== src/pll_divider_word_serializer.sv =====
// PLL divider word serializer.
// Input stream (s_*): one word per request, the receive frequency in hertz.
// Output stream (m_*): 40 words per request, one per serial bit, MSB first:
// 16 bits of N, the byte A<<1, then the 16-bit reference word. m_tuser marks
// the bits after which a latch pulse follows; m_tlast marks the final bit.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while the block is idle.
// Datapath: the sum is divided by the step one quotient bit per cycle, and
// the quotient bits feed a second bit-serial divider by the prescaler
// modulus, which takes each bit in the cycle after it is produced.
// Throughput is set by the serializer emitting one bit per cycle while the
// receiver does not stall. A short queue holds finished N/A words so the
// front can take the next request meanwhile.
// Reset: registers return to their defaults, queue and serializer empty.
// Receiver stall: the current bit holds; once the queue fills, s_tready drops.
module pll_divider_word_serializer import pdws_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] rf_hz
  // Bit stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] serial_bit, [7:1] zero
  output logic [0:0]  m_tuser,   // [0] latch_after
  output logic        m_tlast
);

  cfg_t     cfg;
  logic     q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  na_word_t q_push_word, q_pop_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.if_offset_hz      <= IF_OFFSET_RST;
      cfg.step_hz           <= STEP_RST;
      cfg.prescaler_modulus <= MODULUS_RST;
      cfg.ref_word          <= REF_WORD_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_IF_OFFSET: cfg.if_offset_hz      <= cfg_data;
        REG_STEP:      cfg.step_hz           <= cfg_data;
        REG_MODULUS:   cfg.prescaler_modulus <= cfg_data[7:0];
        REG_REF_WORD:  cfg.ref_word          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  pdws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_word  (q_push_word)
  );

  pdws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_word  (q_push_word),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_word   (q_pop_word)
  );

  pdws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_word  (q_pop_word),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Front goes busy for the division after every accepted request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("front accepted two requests back to back");

  // Front holds a finished word while the queue is full
  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_word))
    else $error("front dropped or changed a pending word");

  // Final bit of a run always carries a latch pulse
  a_last_latch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("final bit without latch pulse");

endmodule

// ===== src/pdws_front.sv =====
module pdws_front import pdws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  output logic        push_valid,
  input  logic        push_ready,
  output na_word_t    push_word
);

  front_state_t state, state_next;

  logic [31:0]           dvd;
  logic [31:0]           rem1;
  logic [7:0]            rem2;
  logic [15:0]           nsh;
  logic                  qbit;
  logic                  qvld;
  logic [STEP_CNT_W-1:0] cnt;

  logic [31:0] div_eff;
  logic [7:0]  mod_eff;
  logic [32:0] trial1, diff1;
  logic [8:0]  trial2, diff2;
  logic        ge1, ge2;
  logic        accept;

  // Divider steps: quotient bits of the first are registered in qbit, then feed the second
  always_comb begin
    div_eff = (cfg.step_hz == 32'd0) ? 32'd1 : cfg.step_hz;
    mod_eff = (cfg.prescaler_modulus < 8'd2) ? 8'd1 : cfg.prescaler_modulus;
    trial1  = {rem1, dvd[31]};
    diff1   = trial1 - {1'b0, div_eff};
    ge1     = trial1 >= {1'b0, div_eff};
    trial2  = {rem2, qbit};
    diff2   = trial2 - {1'b0, mod_eff};
    ge2     = trial2 >= {1'b0, mod_eff};
  end

  assign accept    = s_tvalid && s_tready;
  assign push_word = '{n: nsh, a2: {rem2[6:0], 1'b0}};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshakes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    push_valid = 1'b0;
    unique case (state)
      FR_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = FR_DIV;
      end
      FR_DIV: begin
        if (cnt == STEP_CNT_W'(DIV_STEPS - 1)) state_next = FR_FIN;
      end
      FR_FIN: begin
        state_next = FR_PUSH;
      end
      FR_PUSH: begin
        push_valid = 1'b1;
        s_tready   = push_ready;
        if (push_ready) state_next = s_tvalid ? FR_DIV : FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // Second divider works on the registered quotient bit, enabled by a registered copy of the divide state
  always_ff @(posedge clk) begin
    if (rst) begin
      qvld <= 1'b0;
    end else begin
      qvld <= (state == FR_DIV);
    end
  end

  // Datapath: load on accept, then iterate
  always_ff @(posedge clk) begin
    if (accept) begin
      dvd  <= s_tdata + cfg.if_offset_hz;
      rem1 <= '0;
      rem2 <= '0;
      cnt  <= '0;
    end else begin
      if (state == FR_DIV) begin
        dvd  <= {dvd[30:0], 1'b0};
        rem1 <= ge1 ? diff1[31:0] : trial1[31:0];
        qbit <= ge1;
        cnt  <= cnt + 1'b1;
      end
      if (qvld) begin
        rem2 <= ge2 ? diff2[7:0] : trial2[7:0];
        nsh  <= {nsh[14:0], ge2};
      end
    end
  end

endmodule

// ===== src/pdws_queue.sv =====
module pdws_queue import pdws_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  na_word_t push_word,
  output logic     pop_valid,
  input  logic     pop_ready,
  output na_word_t pop_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  na_word_t          mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming word
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_word;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== src/pdws_back.sv =====
module pdws_back import pdws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  na_word_t   pop_word,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [0:0] m_tuser,
  output logic       m_tlast
);

  logic [RUN_BITS-1:0]  sreg;
  logic [BIT_CNT_W-1:0] bcnt;
  logic                 active;
  logic                 hs, at_end, load;

  assign hs     = m_tvalid && m_tready;
  assign at_end = (bcnt == BIT_CNT_W'(RUN_BITS - 1));
  assign load   = pop_valid && (!active || (hs && at_end));
  assign pop_ready = !active || (hs && at_end);

  assign m_tvalid = active;
  assign m_tdata  = {7'd0, sreg[RUN_BITS-1]};
  assign m_tuser  = (bcnt == BIT_CNT_W'(WORD_BITS - 1)) || at_end;
  assign m_tlast  = at_end;

  // Control: run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (hs && at_end) begin
      active <= 1'b0;
    end
  end

  // Shift out MSB first
  always_ff @(posedge clk) begin
    if (load) begin
      sreg <= {pop_word.n, pop_word.a2, cfg.ref_word};
      bcnt <= '0;
    end else if (hs && !at_end) begin
      sreg <= {sreg[RUN_BITS-2:0], 1'b0};
      bcnt <= bcnt + 1'b1;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pdws_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic data;
    logic latch;
    logic last_bit;
  } bit_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_IF_OFFSET;
  logic [31:0] cfg_data = 32'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'd0;   // [31:0] rf_hz
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [0] serial_bit, [7:1] zero
  logic [0:0]  m_tuser;           // [0] latch_after
  logic        m_tlast;

  // Local copy of the divider settings
  logic [31:0] offset_hz = IF_OFFSET_RST;
  logic [31:0] step_hz = STEP_RST;
  logic [7:0]  modulus = MODULUS_RST;
  logic [15:0] ref_word = REF_WORD_RST;

  logic [31:0] rf_pending[$];
  bit_expect_t expected_bits[$];
  bit_expect_t want_bit;

  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   rx_draw = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;
  int   bits_seen = 0;
  int   quiet_cycles = 0;
  int   fail_cnt = 0;

  pll_divider_word_serializer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Build the 40-bit run: N (16 bits), A << 1 (8 bits), reference word
  function automatic logic [39:0] divider_run(logic [31:0] rf);
    logic [31:0] sum, divisor, quot, mod, n_cnt, a_cnt;
    sum = rf + offset_hz;
    divisor = (step_hz == 32'd0) ? 32'd1 : step_hz;
    quot = sum / divisor;
    mod = (modulus < 8'd2) ? 32'd1 : {24'd0, modulus};
    n_cnt = quot / mod;
    a_cnt = quot - n_cnt * mod;
    return {n_cnt[15:0], a_cnt[6:0], 1'b0, ref_word};
  endfunction

  // Expand one request into its serial bits, MSB first
  task automatic queue_run_bits(logic [31:0] rf);
    logic [39:0] run;
    bit_expect_t e;
    run = divider_run(rf);
    for (int k = 0; k < RUN_BITS; k++) begin
      e.data = run[RUN_BITS - 1 - k];
      e.latch = (k == WORD_BITS - 1) || (k == RUN_BITS - 1);
      e.last_bit = (k == RUN_BITS - 1);
      expected_bits.push_back(e);
    end
  endtask

  // Mostly no gap, some short ones, a few long ones
  function automatic int draw_gap(logic idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_rf();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(30_000_000, 1_000_000_000);
      2: return $urandom_range(0, 4095);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 50_000_000);
    endcase
  endfunction

  // Request driver: predict on accept, then offer the next word after a gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) queue_run_bits(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (rf_pending.size() != 0) begin
          s_tdata <= rf_pending.pop_front();
          s_tvalid <= 1'b1;
          tx_gap = draw_gap(tx_idle_on);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off so the block fills up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && bits_seen >= HOLD_OFF_AT) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_OFF_CYCLES;
    end
  end

  // Bit monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        bits_seen <= bits_seen + 1;
        if (expected_bits.size() == 0) begin
          $error("unexpected word: serial_bit %0b latch_after %0b last %0b",
                 m_tdata[0], m_tuser[0], m_tlast);
          fail_cnt++;
        end else begin
          want_bit = expected_bits.pop_front();
          if (m_tdata[0] !== want_bit.data) begin
            $error("serial_bit: expected %0b, got %0b", want_bit.data, m_tdata[0]);
            fail_cnt++;
          end
          if (m_tuser[0] !== want_bit.latch) begin
            $error("latch_after: expected %0b, got %0b", want_bit.latch, m_tuser[0]);
            fail_cnt++;
          end
          if (m_tlast !== want_bit.last_bit) begin
            $error("last: expected %0b, got %0b", want_bit.last_bit, m_tlast);
            fail_cnt++;
          end
          if (m_tdata[7:1] !== 7'd0) begin
            $error("tdata padding: expected 0, got %0h", m_tdata[7:1]);
            fail_cnt++;
          end
        end
      end
      if (hold_cnt > 0) begin
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        rx_draw = draw_gap(rx_idle_on);
        rx_gap <= (rx_draw > 0) ? rx_draw - 1 : 0;
        m_tready <= (rx_draw == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_IF_OFFSET: offset_hz = val;
      REG_STEP:      step_hz = val;
      REG_MODULUS:   modulus = val[7:0];
      default:       ref_word = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_divider(logic [31:0] off, logic [31:0] stp, logic [7:0] md,
                             logic [15:0] rw);
    write_reg(REG_IF_OFFSET, off);
    write_reg(REG_STEP, stp);
    write_reg(REG_MODULUS, {24'd0, md});
    write_reg(REG_REF_WORD, {16'd0, rw});
  endtask

  // Hold until every request is taken and every bit has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (rf_pending.size() != 0 || s_tvalid || expected_bits.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [31:0] off, stp;
    logic [7:0]  md;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes and typical channels
    rf_pending.push_back(32'd0);
    rf_pending.push_back(32'hFFFF_FFFF);
    rf_pending.push_back(32'hFFFF_FFFF - IF_OFFSET_RST + 32'd1);
    rf_pending.push_back(32'hAAAA_AAAA);
    rf_pending.push_back(32'h5555_5555);
    rf_pending.push_back(32'd145_500_000);
    rf_pending.push_back(32'd433_920_000);
    wait_drained();

    // Unit step, modulus of two: wide main count gets truncated
    set_divider(32'd0, 32'd1, 8'd2, 16'h0000);
    rf_pending.push_back(32'hFFFF_FFFF);
    rf_pending.push_back(32'h1234_5679);
    rf_pending.push_back(32'd3);
    wait_drained();

    // All-ones offset, step and reference word: the sum wraps
    set_divider(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd128, 16'hFFFF);
    rf_pending.push_back(32'd0);
    rf_pending.push_back(32'd1);
    rf_pending.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Zero step and zero modulus
    set_divider(32'd0, 32'd0, 8'd0, 16'h5A5A);
    rf_pending.push_back(32'd777);
    rf_pending.push_back(32'hDEAD_BEEF);
    wait_drained();

    // Modulus of one
    set_divider(32'd1234, 32'd7, 8'd1, 16'hA5A5);
    rf_pending.push_back(32'd1_000_000);
    rf_pending.push_back(32'hFFFF_0000);
    wait_drained();

    // Modulus above 128: swallow count wider than the byte
    set_divider(32'd0, 32'd1, 8'd255, 16'h0F0F);
    rf_pending.push_back(32'd254);
    rf_pending.push_back(32'd200);
    rf_pending.push_back(32'd128);
    wait_drained();

    // Random settings, each phase a batch of random requests
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 3))
        0: off = 32'd0;
        1: off = IF_OFFSET_RST;
        2: off = $urandom_range(1_000_000, 90_000_000);
        default: off = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: stp = 32'd1;
        1: stp = $urandom_range(1, 50);
        2: stp = STEP_RST;
        3: stp = 32'd12_500;
        4: stp = (ph == 4) ? 32'd0 : 32'd25_000;
        default: stp = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: md = 8'd2;
        1: md = 8'd128;
        2: md = MODULUS_RST;
        3: md = 8'($urandom_range(129, 255));
        4: md = 8'($urandom_range(0, 1));
        default: md = 8'($urandom_range(2, 128));
      endcase
      set_divider(off, stp, md, 16'($urandom));
      tx_idle_on <= (ph % 3 != 2);
      rx_idle_on <= (ph % 3 != 2);
      for (int i = 0; i < 44; i++) rf_pending.push_back(rand_rf());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pdws_pkg.sv
src/pdws_front.sv
src/pdws_queue.sv
src/pdws_back.sv
src/pll_divider_word_serializer.sv
tb/sv/tb_top.sv
